/* hw/rtl/sfr_pkg.sv */
`default_nettype none

package sfr_pkg;

    // fixed field widths
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned MAX_RESULTS = 8;
    localparam int unsigned JOB_DATA_W  = MAX_RESULTS * BYTE_W;
    localparam int unsigned LEN_W       = 4;
    localparam int unsigned SHOWN_W     = 16;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_BYTES      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLACEMENT_BYTES  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLACEMENT_LENGTH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CASE_INSENSITIVE   = 3'd4;

    // ascii upper case lies strictly between these two codes
    localparam logic [BYTE_W-1:0] UPPER_BELOW = 8'd64;
    localparam logic [BYTE_W-1:0] UPPER_ABOVE = 8'd91;
    localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'd32;

    // one burst of results caused by one text item
    typedef struct packed {
        logic [JOB_DATA_W-1:0] data;
        logic [LEN_W-1:0]      count;
        logic                  bare;
        logic                  last_item;
        logic [SHOWN_W-1:0]    match_total;
    } job_t;

    function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] c,
                                               input logic            ci);
        logic [BYTE_W-1:0] r;
        r = c;
        if (ci && (c > UPPER_BELOW) && (c < UPPER_ABOVE))
        begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/sfr_text_if.sv */
`default_nettype none

interface sfr_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       text_end;

    modport source (output valid, output text_byte, output text_end, input ready);
    modport sink (input valid, input text_byte, input text_end, output ready);
endinterface

`default_nettype wire

/* hw/rtl/sfr_result_if.sv */
`default_nettype none

interface sfr_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        run_last;
    logic        stream_end;
    logic [15:0] match_count;

    modport source (output valid, output out_byte, output byte_valid, output run_last,
                    output stream_end, output match_count, input ready);
    modport sink (input valid, input out_byte, input byte_valid, input run_last,
                  input stream_end, input match_count, output ready);
endinterface

`default_nettype wire

/* hw/rtl/stream_find_and_replace_core.sv */
`default_nettype none

// channel  | dir | handshake     | payload
// ---------+-----+---------------+----------------------------------------------------
// text     | in  | valid/ready   | text_byte[7:0], text_end
// result   | out | valid/ready   | out_byte[7:0], byte_valid, run_last, stream_end,
//          |     |               | match_count[15:0]
// cfg      | in  | cfg_we        | cfg_index[2:0], cfg_wdata[63:0]
//
// one text item is taken per cycle while the job queue has room; its zero to eight result
// items leave one per cycle through the serializer while the output is not stalled
// the first result of an item goes through the job queue, written when the item is
// taken, and then the output register, and can wait behind earlier bursts or a stall
// a two-entry job queue parts the front from the back; text ready drops only when
// both entries are held, e.g. while a long replacement drains under output stalls
// reset is asynchronous and active low; no clearing pass, the pending window
// holds no data until written

module stream_find_and_replace_core #(
    parameter int MAX_PATTERN = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [sfr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    sfr_text_if.sink                              text,
    sfr_result_if.source                          result
);

    // front to queue
    logic          push;
    logic          q_full;
    sfr_pkg::job_t front_job;

    // queue to back
    logic          head_valid;
    logic          pop;
    sfr_pkg::job_t head_job;

    // front: config registers, pending window, compare and match counter
    sfr_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (text.valid),
        .in_ready  (text.ready),
        .text_byte (text.text_byte),
        .text_end  (text.text_end),
        .q_full    (q_full),
        .push      (push),
        .job       (front_job)
    );

    // short queue of result bursts
    sfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (front_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // back: walks each burst one item per cycle into the output register while the output is not stalled
    sfr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_job    (head_job),
        .pop         (pop),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .out_byte    (result.out_byte),
        .byte_valid  (result.byte_valid),
        .run_last    (result.run_last),
        .stream_end  (result.stream_end),
        .match_count (result.match_count)
    );

endmodule

`default_nettype wire

/* hw/rtl/sfr_front.sv */
`default_nettype none

module sfr_front #(
    parameter int MAX_PATTERN = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [sfr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [sfr_pkg::BYTE_W-1:0]       text_byte,
    input  wire logic                             text_end,
    input  wire logic                             q_full,
    output logic                                  push,
    output sfr_pkg::job_t                         job
);

    localparam int WIN_W  = MAX_PATTERN * sfr_pkg::BYTE_W;
    localparam int FILL_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int WIDE_W = (COUNT_WIDTH > sfr_pkg::SHOWN_W) ? COUNT_WIDTH : sfr_pkg::SHOWN_W;
    localparam int LW     = sfr_pkg::LEN_W;

    logic [sfr_pkg::CFG_DATA_W-1:0] pat_reg;
    logic [LW-1:0]                  plen_raw_reg;
    logic [sfr_pkg::CFG_DATA_W-1:0] repl_reg;
    logic [LW-1:0]                  rlen_raw_reg;
    logic                           ci_reg;

    logic [WIN_W-1:0]       win_reg, win_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;

    logic [LW-1:0]     plen, rlen, plen_new, keep_new, fill_ext, new_fill, drop;
    logic [WIN_W-1:0]  cat;
    logic              full_win, hit, accept;
    logic [WIDE_W-1:0] cnt_wide;

    // effective lengths, clamped
    function automatic logic [LW-1:0] clamp_plen(input logic [LW-1:0] raw);
        logic [LW-1:0] r;
        r = raw;
        if (raw == '0)
        begin
            r = LW'(1);
        end
        else if (raw > LW'(MAX_PATTERN))
        begin
            r = LW'(MAX_PATTERN);
        end
        return r;
    endfunction

    assign plen     = clamp_plen(plen_raw_reg);
    assign rlen     = (rlen_raw_reg > LW'(sfr_pkg::MAX_RESULTS)) ?
                      LW'(sfr_pkg::MAX_RESULTS) : rlen_raw_reg;
    assign plen_new = clamp_plen(cfg_wdata[LW-1:0]);
    assign keep_new = plen_new - LW'(1);
    assign fill_ext = LW'(fill_reg);
    assign drop     = fill_ext - keep_new;
    assign new_fill = fill_ext + LW'(1);
    assign full_win = (new_fill == plen);

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    // pending bytes with the new one placed after them
    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            if (LW'(k) < fill_ext)
            begin
                cat[k*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W] = win_reg[k*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W];
            end
            else
            begin
                cat[k*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W] = text_byte;
            end
        end
    end

    always_comb
    begin
        hit = 1'b1;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            if ((LW'(k) < plen) &&
                (sfr_pkg::fold(cat[k*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W], ci_reg) !=
                 sfr_pkg::fold(pat_reg[k*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W], ci_reg)))
            begin
                hit = 1'b0;
            end
        end
    end

    assign cnt_next = (full_win && hit && (cnt_reg != {COUNT_WIDTH{1'b1}})) ?
                      cnt_reg + COUNT_WIDTH'(1) : cnt_reg;
    assign cnt_wide = WIDE_W'(cnt_next);

    // result burst for this item
    always_comb
    begin
        job.data        = sfr_pkg::JOB_DATA_W'(cat);
        job.count       = '0;
        job.bare        = 1'b0;
        job.last_item   = text_end;
        job.match_total = (cnt_wide > WIDE_W'(16'hFFFF)) ? 16'hFFFF : cnt_wide[15:0];
        win_next        = cat;
        fill_next       = fill_reg;
        priority if (full_win && hit)
        begin
            job.data  = repl_reg;
            job.count = rlen;
            fill_next = '0;
        end
        else if (full_win)
        begin
            job.count = text_end ? plen : LW'(1);
            win_next  = cat >> sfr_pkg::BYTE_W;
            fill_next = text_end ? '0 : FILL_W'(plen - LW'(1));
        end
        else
        begin
            job.count = text_end ? new_fill : '0;
            fill_next = text_end ? '0 : FILL_W'(new_fill);
        end
        if (text_end && (job.count == '0))
        begin
            job.bare  = 1'b1;
            job.count = LW'(1);
            job.data  = '0;
        end
    end

    assign push = accept && (job.count != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg      <= '0;
            plen_raw_reg <= LW'(1);
            repl_reg     <= '0;
            rlen_raw_reg <= '0;
            ci_reg       <= 1'b0;
            fill_reg     <= '0;
            cnt_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sfr_pkg::CFG_PATTERN_BYTES:
                begin
                    pat_reg <= cfg_wdata;
                end
                sfr_pkg::CFG_PATTERN_LENGTH:
                begin
                    plen_raw_reg <= cfg_wdata[LW-1:0];
                    if (fill_ext > keep_new)
                    begin
                        fill_reg <= FILL_W'(keep_new);
                    end
                end
                sfr_pkg::CFG_REPLACEMENT_BYTES:
                begin
                    repl_reg <= cfg_wdata;
                end
                sfr_pkg::CFG_REPLACEMENT_LENGTH:
                begin
                    rlen_raw_reg <= cfg_wdata[LW-1:0];
                end
                sfr_pkg::CFG_CASE_INSENSITIVE:
                begin
                    ci_reg <= cfg_wdata[0];
                end
                default:
                begin
                end
            endcase
        end
        else if (accept)
        begin
            fill_reg <= fill_next;
            cnt_reg  <= cnt_next;
        end
    end

    // window bytes, no reset
    always_ff @(posedge clk)
    begin
        if (cfg_we && (cfg_index == sfr_pkg::CFG_PATTERN_LENGTH) && (fill_ext > keep_new))
        begin
            win_reg <= win_reg >> {drop, 3'b000};
        end
        else if (!cfg_we && accept)
        begin
            win_reg <= win_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/sfr_queue.sv */
`default_nettype none

module sfr_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire sfr_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output sfr_pkg::job_t      head_job
);

    localparam int PTR_W = $clog2(sfr_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(sfr_pkg::QUEUE_DEPTH + 1);

    sfr_pkg::job_t    entry_reg [sfr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full       = (cnt_reg == CNT_W'(sfr_pkg::QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/sfr_back.sv */
`default_nettype none

module sfr_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          head_valid,
    input  wire sfr_pkg::job_t                 head_job,
    output logic                               pop,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [sfr_pkg::BYTE_W-1:0]         out_byte,
    output logic                               byte_valid,
    output logic                               run_last,
    output logic                               stream_end,
    output logic [sfr_pkg::SHOWN_W-1:0]        match_count
);

    localparam int IDX_W = $clog2(sfr_pkg::MAX_RESULTS);

    logic [IDX_W-1:0]              idx_reg;
    logic                          valid_reg;
    logic [sfr_pkg::BYTE_W-1:0]    byte_reg;
    logic                          bv_reg, rl_reg, se_reg;
    logic [sfr_pkg::SHOWN_W-1:0]   mc_reg;
    logic                          advance, last;

    assign advance = head_valid && (!valid_reg || out_ready);
    assign last    = ((sfr_pkg::LEN_W'(idx_reg) + sfr_pkg::LEN_W'(1)) == head_job.count);
    assign pop     = advance && last;

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign byte_valid  = bv_reg;
    assign run_last    = rl_reg;
    assign stream_end  = se_reg;
    assign match_count = mc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= last ? '0 : idx_reg + IDX_W'(1);
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byte_reg <= head_job.data[idx_reg*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W];
            bv_reg   <= !head_job.bare;
            rl_reg   <= last;
            se_reg   <= last && head_job.last_item;
            mc_reg   <= head_job.match_total;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/sfr_checker.sv */
`default_nettype none

module sfr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic [7:0]  res_byte,
    input wire logic        res_byte_valid,
    input wire logic        res_run_last,
    input wire logic        res_stream_end
);

    // a held item stays offered
    a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result item withdrawn while stalled");

    // a held item keeps its byte
    a_byte_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_byte))
        else $error("result byte changed while stalled");

    // end of text always closes a burst
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stream_end |-> res_run_last)
        else $error("stream end without run last");

    // a bare marker only ever stands alone at the end of text
    a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_byte_valid |-> res_run_last && res_stream_end && (res_byte == 8'd0))
        else $error("bare marker outside end of text");

endmodule

bind stream_find_and_replace_core sfr_checker u_sfr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .res_byte       (result.out_byte),
    .res_byte_valid (result.byte_valid),
    .res_run_last   (result.run_last),
    .res_stream_end (result.stream_end)
);

`default_nettype wire

/* test/stream_find_and_replace_core_test.sv */
`timescale 1ns / 100ps

// find-and-replace core bench: directed table first, then random phases with
// idling, one long receiver hold-off and drains between settings changes
module stream_find_and_replace_core_test;

    localparam int MAX_PATTERN    = 8;
    localparam int COUNT_WIDTH    = 16;
    localparam int IDLE_PERCENT   = 23;
    localparam int HOLD_CYCLES    = 300;
    // extra wait after every expected result has been taken, before settings change
    localparam int SETTLE_CYCLES  = 6;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 20;
    localparam int STEADY_PHASE   = 2;
    localparam int STALL_PHASE    = 4;
    localparam int DIRECTED_ROWS  = 24;
    localparam int DIRECTED_SETS  = 5;

    localparam logic [COUNT_WIDTH-1:0]      HITS_MAX  = '1;
    localparam logic [sfr_pkg::SHOWN_W-1:0] SHOWN_MAX = '1;

    typedef struct packed {
        logic [sfr_pkg::BYTE_W-1:0]  out_byte;
        logic                        byte_valid;
        logic                        run_last;
        logic                        stream_end;
        logic [sfr_pkg::SHOWN_W-1:0] match_count;
    } result_item_t;

    typedef struct packed {
        logic [sfr_pkg::CFG_DATA_W-1:0] pattern;
        logic [sfr_pkg::LEN_W-1:0]      pattern_len;
        logic [sfr_pkg::CFG_DATA_W-1:0] replacement;
        logic [sfr_pkg::LEN_W-1:0]      replacement_len;
        logic                           fold_case;
    } settings_t;

    typedef struct packed {
        logic [2:0]                 set_id;
        logic [sfr_pkg::BYTE_W-1:0] text_byte;
        logic                       text_end;
        logic                       typed;
        result_item_t               result;
    } directed_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [sfr_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_wdata;

    sfr_text_if   text_ch();
    sfr_result_if result_ch();

    stream_find_and_replace_core #(
        .MAX_PATTERN(MAX_PATTERN),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .text(text_ch),
        .result(result_ch)
    );

    // settings used by the directed table; set 0 is the reset state and never written
    settings_t directed_settings [DIRECTED_SETS] = '{
        '{64'h0, 4'd1, 64'h0, 4'd0, 1'b0},
        '{64'h0000_0000_0043_6241, 4'd3, 64'hFFEE_DDCC_BBAA_9988, 4'd8, 1'b1},
        '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 64'h0, 4'd0, 1'b0},
        '{64'h0000_0000_0000_007F, 4'd0, 64'h0123_4567_89AB_CDEF, 4'd15, 1'b0},
        '{64'h0807_0605_0403_0201, 4'd15, 64'h0000_0000_0000_002A, 4'd1, 1'b0}
    };

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        // reset pattern is one zero byte with empty replacement: a bare end marker
        '{3'd0, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 16'd1}},
        // no match, the byte itself closes the text
        '{3'd0, 8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b1, 16'd1}},
        // mixed case match with folding, full eight byte replacement
        '{3'd1, 8'h61, 1'b0, 1'b0, '0},
        '{3'd1, 8'h42, 1'b0, 1'b0, '0},
        '{3'd1, 8'h63, 1'b0, 1'b0, '0},
        // codes just outside the upper case range are not folded
        '{3'd1, 8'h40, 1'b0, 1'b0, '0},
        '{3'd1, 8'h5B, 1'b0, 1'b0, '0},
        '{3'd1, 8'h5A, 1'b0, 1'b0, '0},
        '{3'd1, 8'h61, 1'b0, 1'b0, '0},
        '{3'd1, 8'h62, 1'b1, 1'b0, '0},
        // longest pattern matched, nothing emitted, then two bytes left pending
        '{3'd2, 8'hFF, 1'b0, 1'b0, '0},
        '{3'd2, 8'hFF, 1'b0, 1'b0, '0},
        '{3'd2, 8'hFF, 1'b0, 1'b0, '0},
        '{3'd2, 8'hFF, 1'b0, 1'b0, '0},
        '{3'd2, 8'hFF, 1'b0, 1'b0, '0},
        '{3'd2, 8'hFF, 1'b0, 1'b0, '0},
        '{3'd2, 8'hFF, 1'b0, 1'b0, '0},
        '{3'd2, 8'hFF, 1'b0, 1'b0, '0},
        '{3'd2, 8'h80, 1'b0, 1'b0, '0},
        '{3'd2, 8'h01, 1'b0, 1'b0, '0},
        // length zero acts as one and drops the pending bytes, oversize replacement
        '{3'd3, 8'h7F, 1'b0, 1'b0, '0},
        '{3'd3, 8'h55, 1'b1, 1'b0, '0},
        // oversize pattern length acts as eight, end flushes the partial window
        '{3'd4, 8'h01, 1'b0, 1'b0, '0},
        '{3'd4, 8'h02, 1'b1, 1'b0, '0}
    };

    // predictor state: register values as written, pending window, match counter
    settings_t                  live;
    logic [sfr_pkg::BYTE_W-1:0] window [MAX_PATTERN];
    int unsigned                window_fill;
    logic [COUNT_WIDTH-1:0]     hits;
    result_item_t               burst [sfr_pkg::MAX_RESULTS];
    int unsigned                burst_n;

    result_item_t       due_results [$];
    int unsigned        mismatches = 0;
    int unsigned        cycle_count;
    int unsigned        holds_asked = 0;
    int unsigned        holds_done = 0;
    logic               no_idle;

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned span_of(input logic [sfr_pkg::LEN_W-1:0] len);
        if (len == 0)
        begin
            return 1;
        end
        if (len > MAX_PATTERN)
        begin
            return MAX_PATTERN;
        end
        return 32'(len);
    endfunction

    function automatic logic [sfr_pkg::BYTE_W-1:0] fold_byte(
        input logic [sfr_pkg::BYTE_W-1:0] c);
        if (live.fold_case && c > sfr_pkg::UPPER_BELOW && c < sfr_pkg::UPPER_ABOVE)
        begin
            return c + sfr_pkg::CASE_OFFSET;
        end
        return c;
    endfunction

    // keep at most span-1 pending bytes, oldest ones are lost
    task automatic trim_window();
        int unsigned keep;
        int unsigned drop;
        keep = span_of(live.pattern_len) - 1;
        if (window_fill > keep)
        begin
            drop = window_fill - keep;
            for (int k = 0; k < keep; k++)
            begin
                window[k] = window[k + drop];
            end
            window_fill = keep;
        end
    endtask

    task automatic store_register(input logic [sfr_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [sfr_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            sfr_pkg::CFG_PATTERN_BYTES:      live.pattern = data;
            sfr_pkg::CFG_PATTERN_LENGTH:
            begin
                live.pattern_len = data[sfr_pkg::LEN_W-1:0];
                trim_window();
            end
            sfr_pkg::CFG_REPLACEMENT_BYTES:  live.replacement = data;
            sfr_pkg::CFG_REPLACEMENT_LENGTH: live.replacement_len = data[sfr_pkg::LEN_W-1:0];
            sfr_pkg::CFG_CASE_INSENSITIVE:   live.fold_case = data[0];
            default: ;
        endcase
    endtask

    task automatic emit(input logic [sfr_pkg::BYTE_W-1:0] b, input logic carries);
        burst[burst_n] = '{b, carries, 1'b0, 1'b0, '0};
        burst_n++;
    endtask

    // works out the results caused by one text item into burst
    task automatic scan_text_byte(input logic [sfr_pkg::BYTE_W-1:0] b, input logic e);
        int unsigned span;
        int unsigned rlen;
        logic hit;
        span = span_of(live.pattern_len);
        burst_n = 0;
        trim_window();
        window[window_fill] = b;
        window_fill++;
        if (window_fill == span)
        begin
            hit = 1'b1;
            for (int k = 0; k < span; k++)
            begin
                if (fold_byte(window[k]) != fold_byte(live.pattern[8*k +: 8]))
                begin
                    hit = 1'b0;
                end
            end
            if (hit)
            begin
                rlen = (live.replacement_len > sfr_pkg::MAX_RESULTS) ?
                       sfr_pkg::MAX_RESULTS : 32'(live.replacement_len);
                if (hits != HITS_MAX)
                begin
                    hits++;
                end
                for (int k = 0; k < rlen; k++)
                begin
                    emit(live.replacement[8*k +: 8], 1'b1);
                end
                window_fill = 0;
            end
            else
            begin
                emit(window[0], 1'b1);
                for (int k = 0; k < span - 1; k++)
                begin
                    window[k] = window[k + 1];
                end
                window_fill--;
            end
        end
        if (e)
        begin
            for (int k = 0; k < window_fill; k++)
            begin
                emit(window[k], 1'b1);
            end
            window_fill = 0;
            if (burst_n == 0)
            begin
                emit('0, 1'b0);
            end
        end
        for (int k = 0; k < burst_n; k++)
        begin
            burst[k].match_count = (hits > SHOWN_MAX) ? SHOWN_MAX : sfr_pkg::SHOWN_W'(hits);
        end
        if (burst_n > 0)
        begin
            burst[burst_n - 1].run_last = 1'b1;
            burst[burst_n - 1].stream_end = e;
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [sfr_pkg::SHOWN_W-1:0] got,
                               input logic [sfr_pkg::SHOWN_W-1:0] want);
        if (got !== want)
        begin
            report_mismatch(what, 64'(got), 64'(want));
        end
    endtask

    // offer one text item, with random idle cycles ahead of it
    task automatic send_text(input logic [sfr_pkg::BYTE_W-1:0] b, input logic e,
                             input logic typed, input result_item_t typed_result);
        @(negedge clk);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            text_ch.valid <= 1'b0;
            @(negedge clk);
        end
        text_ch.valid     <= 1'b1;
        text_ch.text_byte <= b;
        text_ch.text_end  <= e;
        do
        begin
            @(posedge clk);
        end
        while (text_ch.ready !== 1'b1);
        scan_text_byte(b, e);
        if (typed)
        begin
            due_results.push_back(typed_result);
        end
        else
        begin
            for (int k = 0; k < burst_n; k++)
            begin
                due_results.push_back(burst[k]);
            end
        end
    endtask

    // sender stops and waits until every expected result has left the block
    task automatic wait_drained();
        @(negedge clk);
        text_ch.valid <= 1'b0;
        while (due_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [sfr_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [sfr_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        store_register(idx, data);
    endtask

    task automatic apply_settings(input settings_t s);
        wait_drained();
        write_register(sfr_pkg::CFG_PATTERN_BYTES, s.pattern);
        write_register(sfr_pkg::CFG_PATTERN_LENGTH, sfr_pkg::CFG_DATA_W'(s.pattern_len));
        write_register(sfr_pkg::CFG_REPLACEMENT_BYTES, s.replacement);
        write_register(sfr_pkg::CFG_REPLACEMENT_LENGTH,
                       sfr_pkg::CFG_DATA_W'(s.replacement_len));
        write_register(sfr_pkg::CFG_CASE_INSENSITIVE, sfr_pkg::CFG_DATA_W'(s.fold_case));
        // unused index, must leave every register alone
        write_register(sfr_pkg::CFG_INDEX_W'($urandom_range(
                           32'(sfr_pkg::CFG_CASE_INSENSITIVE) + 1,
                           (1 << sfr_pkg::CFG_INDEX_W) - 1)),
                       {$urandom, $urandom});
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // letters a to d in random case so patterns repeat often in the text
    function automatic logic [sfr_pkg::BYTE_W-1:0] alphabet_byte();
        logic [sfr_pkg::BYTE_W-1:0] c;
        c = 8'h61 + 8'($urandom_range(0, 3));
        if ($urandom_range(0, 1))
        begin
            c = c ^ sfr_pkg::CASE_OFFSET;
        end
        return c;
    endfunction

    function automatic settings_t random_settings();
        settings_t s;
        int unsigned roll;
        int unsigned span;
        roll = $urandom_range(0, 9);
        if (roll == 0)
        begin
            // out of range lengths
            s.pattern_len = $urandom_range(0, 1) ? '0 :
                            sfr_pkg::LEN_W'($urandom_range(MAX_PATTERN + 1, 15));
        end
        else if (roll < 3)
        begin
            s.pattern_len = sfr_pkg::LEN_W'($urandom_range(MAX_PATTERN - 1, MAX_PATTERN));
        end
        else
        begin
            s.pattern_len = sfr_pkg::LEN_W'($urandom_range(1, 4));
        end
        span = span_of(s.pattern_len);
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            if (k >= span || $urandom_range(0, 7) == 0)
            begin
                s.pattern[8*k +: 8] = 8'($urandom_range(0, 255));
            end
            else
            begin
                s.pattern[8*k +: 8] = alphabet_byte();
            end
        end
        s.replacement = {$urandom, $urandom};
        s.replacement_len = sfr_pkg::LEN_W'(($urandom_range(0, 9) == 0) ?
                                            $urandom_range(sfr_pkg::MAX_RESULTS + 1, 15) :
                                            $urandom_range(0, sfr_pkg::MAX_RESULTS));
        s.fold_case = 1'($urandom_range(0, 1));
        return s;
    endfunction

    // filler: a pattern byte for partial matches, or a letter
    function automatic logic [sfr_pkg::BYTE_W-1:0] filler_byte();
        if ($urandom_range(0, 1))
        begin
            return live.pattern[8*$urandom_range(0, span_of(live.pattern_len) - 1) +: 8];
        end
        return alphabet_byte();
    endfunction

    // result checker: each accepted item against the oldest expectation
    always @(posedge clk)
    begin
        result_item_t want;
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (due_results.size() == 0)
            begin
                report_mismatch("unexpected result item, out_byte",
                                64'(result_ch.out_byte), 0);
            end
            else
            begin
                want = due_results.pop_front();
                check_field("out_byte", sfr_pkg::SHOWN_W'(result_ch.out_byte),
                            sfr_pkg::SHOWN_W'(want.out_byte));
                check_field("byte_valid", sfr_pkg::SHOWN_W'(result_ch.byte_valid),
                            sfr_pkg::SHOWN_W'(want.byte_valid));
                check_field("run_last", sfr_pkg::SHOWN_W'(result_ch.run_last),
                            sfr_pkg::SHOWN_W'(want.run_last));
                check_field("stream_end", sfr_pkg::SHOWN_W'(result_ch.stream_end),
                            sfr_pkg::SHOWN_W'(want.stream_end));
                check_field("match_count", result_ch.match_count, want.match_count);
            end
        end
    end

    // receiver: random idling, one long hold-off when asked
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_done != holds_asked)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                holds_done++;
            end
            else
            begin
                result_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // stimulus
    initial
    begin
        int unsigned phase;
        int unsigned sent;
        int unsigned span;
        int unsigned roll;
        int unsigned pos;
        logic [sfr_pkg::BYTE_W-1:0] b;
        logic [2:0] prev_set;
        settings_t s;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_wdata         = '0;
        text_ch.valid     = 1'b0;
        text_ch.text_byte = '0;
        text_ch.text_end  = 1'b0;
        no_idle           = 1'b0;

        // predictor reset
        live        = directed_settings[0];
        window_fill = 0;
        hits        = '0;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            window[k] = '0;
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table, settings change between groups of rows
        prev_set = 3'd0;
        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (directed_rows[r].set_id != prev_set)
            begin
                prev_set = directed_rows[r].set_id;
                apply_settings(directed_settings[prev_set]);
            end
            send_text(directed_rows[r].text_byte, directed_rows[r].text_end,
                      directed_rows[r].typed, directed_rows[r].result);
        end

        // random phases: mostly pattern runs with random case and breaks
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            s = random_settings();
            if (phase == STALL_PHASE)
            begin
                // long replacements so the hold-off backs up into the text input
                s.replacement_len = sfr_pkg::LEN_W'(sfr_pkg::MAX_RESULTS);
            end
            apply_settings(s);
            no_idle = (phase == STEADY_PHASE);
            span = span_of(live.pattern_len);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if (phase == STALL_PHASE && sent >= 4 && holds_asked == 0)
                begin
                    holds_asked++;
                end
                roll = $urandom_range(0, 9);
                if (roll < 6)
                begin
                    // a quarter of the runs get one byte spoiled
                    pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, span - 1) : span;
                    for (int k = 0; k < span; k++)
                    begin
                        b = live.pattern[8*k +: 8];
                        if (k == pos)
                        begin
                            b = 8'($urandom_range(0, 255));
                        end
                        else if (live.fold_case && $urandom_range(0, 1)
                                 && (b | sfr_pkg::CASE_OFFSET) >
                                    (sfr_pkg::UPPER_BELOW | sfr_pkg::CASE_OFFSET)
                                 && (b | sfr_pkg::CASE_OFFSET) <
                                    (sfr_pkg::UPPER_ABOVE | sfr_pkg::CASE_OFFSET))
                        begin
                            b = b ^ sfr_pkg::CASE_OFFSET;
                        end
                        send_text(b, 1'b0, 1'b0, '0);
                        sent++;
                    end
                end
                else if (roll < 9)
                begin
                    send_text(filler_byte(), $urandom_range(0, 9) == 0, 1'b0, '0);
                    sent++;
                end
                else
                begin
                    send_text(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
                    sent++;
                end
            end
            // some phases leave bytes pending across the next settings change
            if ($urandom_range(0, 3) != 0)
            begin
                send_text(filler_byte(), 1'b1, 1'b0, '0);
            end
        end
        no_idle = 1'b0;

        wait_drained();
        if (mismatches == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
